FILE: rtl/pwmtsc_pkg.sv
package pwmtsc_pkg;

    localparam logic CFG_BUS_CLOCK = 1'b0;
    localparam logic CFG_BUS_DIV   = 1'b1;

    localparam logic [1:0] MODE_LOW  = 2'd0;
    localparam logic [1:0] MODE_HIGH = 2'd1;
    localparam logic [1:0] MODE_PWM  = 2'd2;

    localparam logic [15:0] DUTY_FULL = 16'd10000;
    localparam logic [13:0] DUTY_HALF = 14'd5000;

    // x / 10000 == (x * DUTY_RECIP) >> RECIP_SHIFT for any 32-bit x
    localparam logic [31:0] DUTY_RECIP  = 32'hD1B71759;
    localparam int          RECIP_SHIFT = 45;

    typedef enum logic [1:0] {
        CLS_ERR,
        CLS_LOW,
        CLS_HIGH,
        CLS_PWM
    } t_cls;

    typedef struct packed {
        logic [31:0] freq_hz;
        logic [15:0] duty_pm;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [1:0]  drive_mode;
        logic [15:0] prescale_value;
        logic [15:0] reload_value;
        logic [16:0] compare_value;
    } t_res;

    typedef struct packed {
        logic [31:0] freq;
        logic [15:0] duty;
        logic [31:0] clk;
        t_cls        cls;
        logic [15:0] psc;
        logic        psc_err;
        logic [16:0] cnt;
        logic        cnt_err;
    } t_side;

endpackage

FILE: rtl/pwmtsc_div.sv
module pwmtsc_div
    import pwmtsc_pkg::*;
#(
    parameter int NW = 32,
    parameter int DW = 49,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    // index 0 is the input, index k+1 the register after bit step k
    logic          s_v    [0:NW];
    logic [NW-1:0] s_num  [0:NW];
    logic [NW-1:0] s_quo  [0:NW];
    logic [DW-1:0] s_rem  [0:NW];
    logic [DW-1:0] s_den  [0:NW];
    logic [SW-1:0] s_side [0:NW];

    assign s_v[0]    = i_valid;
    assign s_num[0]  = i_num;
    assign s_quo[0]  = '0;
    assign s_rem[0]  = '0;
    assign s_den[0]  = i_den;
    assign s_side[0] = i_side;

    for (genvar g = 0; g < NW; g++) begin : g_step
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] n_rem;

        always_comb begin
            trial = {s_rem[g], s_num[g][NW-1]};
            ge    = (trial >= {1'b0, s_den[g]});
            n_rem = ge ? DW'(trial - {1'b0, s_den[g]}) : trial[DW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_v[g+1] <= 1'b0;
            end else begin
                s_v[g+1] <= s_v[g];
            end
            s_num[g+1]  <= {s_num[g][NW-2:0], 1'b0};
            s_quo[g+1]  <= {s_quo[g][NW-2:0], ge};
            s_rem[g+1]  <= n_rem;
            s_den[g+1]  <= s_den[g];
            s_side[g+1] <= s_side[g];
        end
    end

    assign o_valid = s_v[NW];
    assign o_quo   = s_quo[NW];
    assign o_rem   = s_rem[NW];
    assign o_side  = s_side[NW];

endmodule

FILE: rtl/pwm_timer_setting_calc.sv
// PWM timer setting calculator.
// Config: write bus_clock_hz (index 0) and bus_divided (index 1) through
// i_cfg_we/i_cfg_idx/i_cfg_data while no request is in flight.
// Requests: a transfer happens on each edge with start high and busy low.
// busy stays low, so a new request may enter every cycle.
// Results: o_strobe marks o_res for exactly one cycle; results come out in
// request order. Throughput is one request per cycle. The pipeline holds
// two restoring dividers of 32 stages each (prescaler, count), plus eight
// stages for classification, products, prescaler and count range, the
// two-step reciprocal multiply for the rounded pulse and output register.
// Reset clears all valid bits and the config registers; requests in flight
// are dropped. The receiver cannot stall: every result is taken on the edge
// that ends its strobe cycle.
module pwm_timer_setting_calc
    import pwmtsc_pkg::*;
#(
    parameter int COUNTER_SPAN = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_strobe,
    output t_res        o_res
);

    localparam int SPAN_W = $clog2(COUNTER_SPAN + 1);
    localparam int DW     = 32 + SPAN_W > 49 ? 32 + SPAN_W : 49;
    localparam int SW     = $bits(t_side);

    logic [31:0] r_bus_clk;
    logic        r_bus_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_clk <= '0;
            r_bus_div <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BUS_CLOCK: r_bus_clk <= i_cfg_data;
                CFG_BUS_DIV:   r_bus_div <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage A: classify
    logic [31:0] n_tclk;
    t_cls        n_cls;
    logic        r_a_v;
    t_side       r_a;

    always_comb begin
        n_tclk = r_bus_div ? {r_bus_clk[30:0], 1'b0} : r_bus_clk;
        if (i_req.freq_hz == '0 || i_req.duty_pm > DUTY_FULL) begin
            n_cls = CLS_ERR;
        end else if (i_req.duty_pm == '0) begin
            n_cls = CLS_LOW;
        end else if (i_req.duty_pm == DUTY_FULL) begin
            n_cls = CLS_HIGH;
        end else if (n_tclk == '0 || i_req.freq_hz > n_tclk) begin
            n_cls = CLS_ERR;
        end else begin
            n_cls = CLS_PWM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= start && !busy;
        end
        r_a.freq    <= i_req.freq_hz;
        r_a.duty    <= i_req.duty_pm;
        r_a.clk     <= n_tclk;
        r_a.cls     <= n_cls;
        r_a.psc     <= '0;
        r_a.psc_err <= 1'b0;
        r_a.cnt     <= '0;
        r_a.cnt_err <= 1'b0;
    end

    // stage B: freq * span
    logic          r_b_v;
    t_side         r_b;
    logic [DW-1:0] r_b_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= r_a_v;
        end
        r_b     <= r_a;
        r_b_den <= DW'(r_a.freq) * DW'(COUNTER_SPAN);
    end

    logic          d1_v;
    logic [31:0]   d1_quo;
    logic [DW-1:0] d1_rem;
    logic [SW-1:0] d1_side;

    pwmtsc_div #(.NW(32), .DW(DW), .SW(SW)) u_div_psc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_v),
        .i_num   (r_b.clk),
        .i_den   (r_b_den),
        .i_side  (r_b),
        .o_valid (d1_v),
        .o_quo   (d1_quo),
        .o_rem   (d1_rem),
        .o_side  (d1_side)
    );

    // stage C: prescaler from ceiling quotient
    t_side       c_in;
    logic [32:0] n_ceil;
    logic [32:0] n_psc;
    logic        r_c_v;
    t_side       r_c;

    always_comb begin
        n_ceil       = {1'b0, d1_quo} + 33'(d1_rem != '0);
        n_psc        = (n_ceil != '0) ? n_ceil - 33'd1 : '0;
        c_in         = t_side'(d1_side);
        c_in.psc     = n_psc[15:0];
        c_in.psc_err = (n_psc[32:16] != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else begin
            r_c_v <= d1_v;
        end
        r_c <= c_in;
    end

    // stage D: (psc + 1) * freq
    logic          r_d_v;
    t_side         r_d;
    logic [DW-1:0] r_d_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else begin
            r_d_v <= r_c_v;
        end
        r_d     <= r_c;
        r_d_den <= DW'({1'b0, r_c.psc} + 17'd1) * DW'(r_c.freq);
    end

    logic          d2_v;
    logic [31:0]   d2_quo;
    logic [DW-1:0] d2_rem;
    logic [SW-1:0] d2_side;

    pwmtsc_div #(.NW(32), .DW(DW), .SW(SW)) u_div_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_v),
        .i_num   (r_d.clk),
        .i_den   (r_d_den),
        .i_side  (r_d),
        .o_valid (d2_v),
        .o_quo   (d2_quo),
        .o_rem   (d2_rem),
        .o_side  (d2_side)
    );

    // stage E: count range and rounded pulse numerator
    t_side       e_in;
    logic        r_e_v;
    t_side       r_e;
    logic [31:0] r_e_num;

    always_comb begin
        e_in         = t_side'(d2_side);
        e_in.cnt     = d2_quo[16:0];
        e_in.cnt_err = (d2_quo < 32'd2) || (d2_quo > 32'(COUNTER_SPAN));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else begin
            r_e_v <= d2_v;
        end
        r_e     <= e_in;
        r_e_num <= 32'(d2_quo[16:0]) * 32'(e_in.duty[13:0]) + 32'(DUTY_HALF);
    end

    // stage P: partial products of numerator times reciprocal of 10000
    logic        r_p_v;
    t_side       r_p;
    logic [47:0] r_p_lo;
    logic [47:0] r_p_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else begin
            r_p_v <= r_e_v;
        end
        r_p    <= r_e;
        r_p_lo <= {16'b0, r_e_num} * {32'b0, DUTY_RECIP[15:0]};
        r_p_hi <= {16'b0, r_e_num} * {32'b0, DUTY_RECIP[31:16]};
    end

    // stage Q: sum and shift gives the rounded pulse
    logic [63:0] n_prod;
    logic        r_q_v;
    t_side       r_q;
    logic [16:0] r_q_pulse;

    always_comb begin
        n_prod = {16'b0, r_p_lo} + {r_p_hi, 16'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v <= 1'b0;
        end else begin
            r_q_v <= r_p_v;
        end
        r_q       <= r_p;
        r_q_pulse <= n_prod[RECIP_SHIFT +: 17];
    end

    // stage F: output register
    t_side f_in;
    t_res  n_res;
    logic  r_strobe;
    t_res  r_res;

    always_comb begin
        f_in  = r_q;
        n_res = '0;
        case (f_in.cls)
            CLS_LOW:  n_res.drive_mode = MODE_LOW;
            CLS_HIGH: n_res.drive_mode = MODE_HIGH;
            CLS_PWM: begin
                if (f_in.psc_err || f_in.cnt_err) begin
                    n_res.status = 1'b1;
                end else begin
                    n_res.drive_mode     = MODE_PWM;
                    n_res.prescale_value = f_in.psc;
                    n_res.reload_value   = 16'(f_in.cnt - 17'd1);
                    n_res.compare_value  = r_q_pulse;
                end
            end
            default:  n_res.status = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_q_v;
        end
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

FILE: sim/tb_pwm_timer_setting_calc.sv
module tb_pwm_timer_setting_calc;
    import pwmtsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 72;

    typedef struct {
        logic        cfg_we;
        logic [31:0] clk_val;
        logic        div_val;
        t_req        req;
        logic        typed;
        t_res        res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        start;
    logic        busy;
    t_req        i_req;
    logic        o_strobe;
    t_res        o_res;

    logic [31:0] bus_clock_hz;
    logic        bus_divided;
    t_res        pending_settings[$];
    int          errors;
    t_row        rows[$];

    pwm_timer_setting_calc i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .start     (start),
        .busy      (busy),
        .i_req     (i_req),
        .o_strobe  (o_strobe),
        .o_res     (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic t_res calc_settings(t_req r);
        t_res        s;
        logic [31:0] tclk;
        logic [63:0] span_f;
        logic [63:0] psc;
        logic [63:0] counts;
        logic [63:0] pulse;
        s = '0;
        if (r.freq_hz == 0 || r.duty_pm > DUTY_FULL) begin
            s.status = 1'b1;
            return s;
        end
        if (r.duty_pm == 0) begin
            s.drive_mode = MODE_LOW;
            return s;
        end
        if (r.duty_pm == DUTY_FULL) begin
            s.drive_mode = MODE_HIGH;
            return s;
        end
        tclk = bus_divided ? bus_clock_hz << 1 : bus_clock_hz;
        if (tclk == 0 || r.freq_hz > tclk) begin
            s.status = 1'b1;
            return s;
        end
        span_f = 64'(r.freq_hz) * 64'd65536;
        psc = (64'(tclk) + span_f - 1) / span_f;
        if (psc != 0) psc--;
        if (psc > 65535) begin
            s.status = 1'b1;
            return s;
        end
        counts = 64'(tclk) / ((psc + 1) * 64'(r.freq_hz));
        if (counts < 2 || counts > 65536) begin
            s.status = 1'b1;
            return s;
        end
        pulse = (counts * 64'(r.duty_pm) + 5000) / 10000;
        s.drive_mode     = MODE_PWM;
        s.prescale_value = psc[15:0];
        s.reload_value   = 16'(counts - 1);
        s.compare_value  = pulse[16:0];
        return s;
    endfunction

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_strobe) begin
            if (pending_settings.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                e = pending_settings.pop_front();
                if (o_res.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_res.status);
                    errors++;
                end
                if (o_res.drive_mode !== e.drive_mode) begin
                    $error("drive_mode exp %0d got %0d", e.drive_mode, o_res.drive_mode);
                    errors++;
                end
                if (o_res.prescale_value !== e.prescale_value) begin
                    $error("prescale_value exp %0d got %0d",
                           e.prescale_value, o_res.prescale_value);
                    errors++;
                end
                if (o_res.reload_value !== e.reload_value) begin
                    $error("reload_value exp %0d got %0d", e.reload_value, o_res.reload_value);
                    errors++;
                end
                if (o_res.compare_value !== e.compare_value) begin
                    $error("compare_value exp %0d got %0d",
                           e.compare_value, o_res.compare_value);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_BUS_CLOCK) bus_clock_hz = val;
        else bus_divided = val[0];
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_settings.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_clock(logic [31:0] clk_val, logic div_val);
        drain();
        write_reg(CFG_BUS_CLOCK, clk_val);
        write_reg(CFG_BUS_DIV, {31'b0, div_val});
        i_cfg_we <= 1'b0;
    endtask

    task automatic send(t_req r, logic gaps);
        if (gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_settings.push_back(calc_settings(r));
    endtask

    function automatic t_req rand_req();
        t_req r;
        int   k;
        k = $urandom_range(0, 19);
        r.freq_hz = $urandom();
        if (k < 12) r.freq_hz = $urandom_range(1, 200000);
        else if (k < 14) r.freq_hz = $urandom_range(1, 100);
        else if (k == 14) r.freq_hz = 0;
        r.duty_pm = 16'($urandom_range(1, 9999));
        k = $urandom_range(0, 19);
        if (k == 0) r.duty_pm = 0;
        else if (k == 1) r.duty_pm = DUTY_FULL;
        else if (k == 2) r.duty_pm = 16'($urandom_range(10001, 65535));
        return r;
    endfunction

    function automatic t_row mk(logic we, logic [31:0] c, logic d, logic [31:0] f,
                                logic [15:0] du, logic typed, t_res r);
        t_row w;
        w.cfg_we = we; w.clk_val = c; w.div_val = d;
        w.req.freq_hz = f; w.req.duty_pm = du; w.typed = typed; w.res = r;
        return w;
    endfunction

    initial begin
        t_req        r;
        t_res        err_res;
        t_res        hi_res;
        logic [31:0] clks[5];
        errors     = 0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_BUS_CLOCK;
        i_cfg_data = '0;
        start      = 1'b0;
        i_req      = '0;
        bus_clock_hz = '0;
        bus_divided  = 1'b0;
        err_res = '0; err_res.status = 1'b1;
        hi_res  = '0; hi_res.drive_mode = MODE_HIGH;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: clock zero
        rows.push_back(mk(0, 0, 0, 1000, 5000, 1, err_res));
        rows.push_back(mk(0, 0, 0, 0, 5000, 1, err_res));
        rows.push_back(mk(0, 0, 0, 1000, 10001, 1, err_res));
        rows.push_back(mk(0, 0, 0, 1000, 16'hFFFF, 1, err_res));
        rows.push_back(mk(0, 0, 0, 32'hFFFFFFFF, 0, 1, '0));
        rows.push_back(mk(0, 0, 0, 1, 10000, 1, hi_res));
        rows.push_back(mk(1, 72000000, 0, 1000, 5000, 0, '0));
        rows.push_back(mk(0, 0, 0, 1, 1, 0, '0));
        rows.push_back(mk(0, 0, 0, 1, 9999, 0, '0));
        rows.push_back(mk(0, 0, 0, 72000000, 5000, 1, err_res));
        rows.push_back(mk(0, 0, 0, 36000000, 5000, 0, '0));
        rows.push_back(mk(0, 0, 0, 72000001, 5000, 1, err_res));
        rows.push_back(mk(0, 0, 0, 32'hFFFFFFFF, 5000, 1, err_res));
        rows.push_back(mk(0, 0, 0, 1099, 1, 0, '0));
        rows.push_back(mk(1, 36000000, 1, 1000, 2500, 0, '0));
        rows.push_back(mk(1, 32'hFFFFFFFF, 0, 1, 5000, 0, '0));
        rows.push_back(mk(0, 0, 0, 65536, 5000, 0, '0));
        rows.push_back(mk(0, 0, 0, 32'h7FFFFFFF, 5000, 0, '0));
        rows.push_back(mk(1, 32'h80000000, 1, 1, 5000, 1, err_res));
        rows.push_back(mk(1, 32'hFFFFFFFF, 1, 3, 7777, 0, '0));
        rows.push_back(mk(1, 65536, 0, 1, 5000, 0, '0));
        rows.push_back(mk(0, 0, 0, 1, 1, 0, '0));

        foreach (rows[i]) begin
            if (rows[i].cfg_we) set_clock(rows[i].clk_val, rows[i].div_val);
            if (rows[i].typed) begin
                pending_settings.push_back(rows[i].res);
                start <= 1'b1;
                i_req <= rows[i].req;
                @(posedge i_clk);
                while (busy) @(posedge i_clk);
            end else begin
                send(rows[i].req, 1'b0);
            end
        end

        clks = '{72000000, 1000000, 32'hFFFFFFFF, 170000000, 0};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 5) set_clock(clks[ph], ph[0]);
            else set_clock($urandom(), 1'($urandom_range(0, 1)));
            for (int n = 0; n < 100; n++) begin
                r = rand_req();
                send(r, ph < 5);
            end
        end

        drain();
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
